/* rtl/stai_pkg.sv */
// stai_pkg: constants, rom tables and types shared by the toe angle lookup
// depends on nothing; every other file imports it
package stai_pkg;

    localparam int TABLE_POINTS = 21;
    localparam int LANES        = 2;
    localparam int LANE_L       = 0;
    localparam int LANE_R       = 1;

    localparam int ANGLE_W   = 16;
    localparam int ANG_EXT_W = ANGLE_W + 1;
    localparam int TOE_W     = 16;
    localparam int ROM_W     = 17;
    localparam int IDX_W     = $clog2(TABLE_POINTS);
    localparam int CNT_W     = $clog2(TABLE_POINTS + 1);

    // breakpoint spacing is BP_ODD * 2^BP_SHIFT in q8.8 degrees
    localparam int BP_ODD   = 9;
    localparam int BP_SHIFT = 8;
    localparam int BP_STEP  = BP_ODD << BP_SHIFT;
    localparam int FRAC_W   = $clog2(BP_STEP);

    localparam int N_W   = 30;
    localparam int MAG_W = 29;
    localparam int LO_W  = 14;
    localparam int HI_W  = MAG_W - LO_W;
    localparam int K_W   = 32;
    localparam logic [K_W-1:0] RAD_K = 32'd2456332553;
    localparam int P_W   = MAG_W + K_W;
    localparam int R_W   = P_W - K_W - BP_SHIFT;
    localparam logic [P_W-1:0] RND = P_W'(BP_STEP) << (K_W - 1);

    // reciprocal of BP_ODD, exact for dividends of R_W bits
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 21;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + BP_ODD - 1) / BP_ODD;
    localparam int PROD_W      = R_W + RECIP_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic signed [ANG_EXT_W-1:0] BP_Q88 [TABLE_POINTS] = '{
        -17'sd23040, -17'sd20736, -17'sd18432, -17'sd16128, -17'sd13824,
        -17'sd11520, -17'sd9216,  -17'sd6912,  -17'sd4608,  -17'sd2304,
        17'sd0,      17'sd2304,   17'sd4608,   17'sd6912,   17'sd9216,
        17'sd11520,  17'sd13824,  17'sd16128,  17'sd18432,  17'sd20736,
        17'sd23040
    };

    localparam logic signed [ROM_W-1:0] TOE_MDEG [TABLE_POINTS] = '{
        -17'sd32535, -17'sd29422, -17'sd26304, -17'sd23171, -17'sd20015,
        -17'sd16827, -17'sd13597, -17'sd10312, -17'sd6961,  -17'sd3530,
        17'sd0,      17'sd3648,   17'sd7441,   17'sd11413,  17'sd15608,
        17'sd20092,  17'sd24959,  17'sd30368,  17'sd36611,  17'sd44391,
        17'sd57063
    };

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] frac;
    } lane_t;

    typedef lane_t [LANES-1:0] item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // toe step from entry idx to the next, zero past the last entry
    function automatic logic signed [ROM_W-1:0] toe_delta(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nx;
        logic signed [ROM_W-1:0] d;
        nx = idx + IDX_W'(1);
        if (idx >= IDX_W'(TABLE_POINTS - 1))
        begin
            d = '0;
        end
        else
        begin
            d = TOE_MDEG[nx] - TOE_MDEG[idx];
        end
        return d;
    endfunction

endpackage

/* rtl/stai_in_if.sv */
// stai_in_if: request channel carrying one steering angle
// depends on stai_pkg
interface stai_in_if;
    import stai_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] steer_angle;

    modport source (output valid, output steer_angle, input ready);
    modport sink   (input valid, input steer_angle, output ready);
endinterface

/* rtl/stai_out_if.sv */
// stai_out_if: result channel carrying left and right toe angles
// depends on stai_pkg
interface stai_out_if;
    import stai_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [TOE_W-1:0] left_toe;
    logic signed [TOE_W-1:0] right_toe;

    modport source (output valid, output left_toe, output right_toe, input ready);
    modport sink   (input valid, input left_toe, input right_toe, output ready);
endinterface

/* rtl/stai_front.sv */
// stai_front: accepts angles, finds the table interval and offset per lane
// depends on stai_pkg and stai_in_if
module stai_front (
    input  logic            clk,
    input  logic            rst_n,
    stai_in_if.sink         in_ch,
    output logic            f_vld,
    output stai_pkg::item_t f_item,
    input  logic            f_rdy
);
    import stai_pkg::*;

    logic  f_vld_reg;
    logic  f_vld_next;
    item_t f_item_reg;
    item_t f_item_next;
    logic  accept;
    logic signed [ANG_EXT_W-1:0] a_l;
    logic signed [ANG_EXT_W-1:0] a_r;

    function automatic lane_t classify(input logic signed [ANG_EXT_W-1:0] a);
        logic [TABLE_POINTS-1:0]     ge;
        logic [CNT_W-1:0]            cnt;
        logic [IDX_W-1:0]            lo;
        logic signed [ANG_EXT_W:0]   diff;
        lane_t                       res;
        for (int j = 0; j < TABLE_POINTS; j++)
        begin
            ge[j] = (a >= BP_Q88[j]);
        end
        cnt = CNT_W'($countones(ge));
        lo  = '0;
        diff = '0;
        priority if (cnt == '0)
        begin
            res.idx  = '0;
            res.frac = '0;
        end
        else if (cnt == CNT_W'(TABLE_POINTS))
        begin
            res.idx  = IDX_W'(TABLE_POINTS - 1);
            res.frac = '0;
        end
        else
        begin
            lo   = IDX_W'(cnt - CNT_W'(1));
            diff = (ANG_EXT_W + 1)'(a) - (ANG_EXT_W + 1)'(BP_Q88[lo]);
            res.idx  = lo;
            res.frac = diff[FRAC_W-1:0];
        end
        return res;
    endfunction

    assign in_ch.ready = !f_vld_reg || f_rdy;
    assign accept      = in_ch.valid && in_ch.ready;
    assign a_l         = ANG_EXT_W'(in_ch.steer_angle);
    assign a_r         = -a_l;

    always_comb
    begin
        f_item_next         = f_item_reg;
        f_vld_next          = f_vld_reg;
        if (accept)
        begin
            f_item_next[LANE_L] = classify(a_l);
            f_item_next[LANE_R] = classify(a_r);
            f_vld_next          = 1'b1;
        end
        else if (f_rdy)
        begin
            f_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= f_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_item_reg <= f_item_next;
    end

    assign f_vld  = f_vld_reg;
    assign f_item = f_item_reg;
endmodule

/* rtl/stai_fifo.sv */
// stai_fifo: short queue between the classify front and the arithmetic back
// depends on stai_pkg
module stai_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_vld,
    output logic              push_rdy,
    input  stai_pkg::item_t   push_item,
    output logic              pop_vld,
    input  logic              pop,
    output stai_pkg::item_t   pop_item,
    output stai_pkg::q_stat_t stat
);
    import stai_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign push_rdy   = !stat.full;
    assign pop_vld    = !stat.empty;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_vld && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

/* rtl/stai_back.sv */
// stai_back: interpolation, radian scaling and rounding pipeline, two lanes
// depends on stai_pkg and stai_out_if
module stai_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_vld,
    input  stai_pkg::item_t q_item,
    output logic            q_pop,
    stai_out_if.source      out_ch
);
    import stai_pkg::*;

    logic en;

    logic s1_vld_reg;
    logic s2_vld_reg;
    logic s3_vld_reg;
    logic out_vld_reg;

    logic [MAG_W-1:0]        mag_reg  [LANES];
    logic [MAG_W-1:0]        mag_next [LANES];
    logic                    flip1_reg  [LANES];
    logic                    flip1_next [LANES];
    logic [HI_W+K_W-1:0]     ph_reg  [LANES];
    logic [HI_W+K_W-1:0]     ph_next [LANES];
    logic [LO_W+K_W-1:0]     pl_reg  [LANES];
    logic [LO_W+K_W-1:0]     pl_next [LANES];
    logic                    flip2_reg [LANES];
    logic [R_W-1:0]          r_reg  [LANES];
    logic [R_W-1:0]          r_next [LANES];
    logic                    flip3_reg [LANES];
    logic signed [TOE_W-1:0] toe_reg  [LANES];
    logic signed [TOE_W-1:0] toe_next [LANES];

    assign en    = !out_vld_reg || out_ch.ready;
    assign q_pop = en && q_vld;

    // numerator lo_toe*step + frac*(hi_toe - lo_toe), split into sign and magnitude
    always_comb
    begin
        logic signed [N_W-1:0]   n;
        logic signed [ROM_W-1:0] lo_t;
        logic signed [ROM_W-1:0] dt;
        for (int k = 0; k < LANES; k++)
        begin
            lo_t = TOE_MDEG[q_item[k].idx];
            dt   = toe_delta(q_item[k].idx);
            n    = N_W'(lo_t) * N_W'(BP_STEP)
                 + N_W'($signed({1'b0, q_item[k].frac})) * N_W'(dt);
            mag_next[k]   = MAG_W'(n[N_W-1] ? -n : n);
            flip1_next[k] = (k == LANE_R) ? !n[N_W-1] : n[N_W-1];
        end
    end

    // magnitude times scale, as two partial products
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            ph_next[k] = (HI_W + K_W)'(mag_reg[k][MAG_W-1:LO_W]) * (HI_W + K_W)'(RAD_K);
            pl_next[k] = (LO_W + K_W)'(mag_reg[k][LO_W-1:0]) * (LO_W + K_W)'(RAD_K);
        end
    end

    // sum with half divisor, drop the power of two part of the divisor
    always_comb
    begin
        logic [P_W-1:0] p;
        for (int k = 0; k < LANES; k++)
        begin
            p = (P_W'(ph_reg[k]) << LO_W) + P_W'(pl_reg[k]) + RND;
            r_next[k] = p[P_W-1:K_W+BP_SHIFT];
        end
    end

    // divide by the odd part through its reciprocal, then apply the sign
    always_comb
    begin
        logic [PROD_W-1:0]       prod;
        logic signed [TOE_W-1:0] qs;
        for (int k = 0; k < LANES; k++)
        begin
            prod = PROD_W'(r_reg[k]) * PROD_W'(RECIP);
            qs   = $signed(prod[RECIP_SHIFT +: TOE_W]);
            toe_next[k] = flip3_reg[k] ? -qs : qs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= q_vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                mag_reg[k]   <= mag_next[k];
                flip1_reg[k] <= flip1_next[k];
                ph_reg[k]    <= ph_next[k];
                pl_reg[k]    <= pl_next[k];
                flip2_reg[k] <= flip1_reg[k];
                r_reg[k]     <= r_next[k];
                flip3_reg[k] <= flip2_reg[k];
                toe_reg[k]   <= toe_next[k];
            end
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.left_toe  = toe_reg[LANE_L];
    assign out_ch.right_toe = toe_reg[LANE_R];
endmodule

/* rtl/steering_toe_angle_interp.sv */
// steering_toe_angle_interp: top level of the steering to toe angle lookup
// depends on stai_pkg, stai_in_if, stai_out_if, stai_front, stai_fifo, stai_back
//
// usage
//   in_ch carries one request per steering angle (signed q8.8 degrees) on
//   valid/ready; out_ch returns left_toe and right_toe (signed, 2^-15 rad)
//   on valid/ready, one result per request, in request order
//   the front stage finds the table interval for the angle and for its
//   negation, a two-entry queue decouples it from the back pipeline, which
//   does the interpolation, scaling to radians and rounding
//   path: front register, queue, then the magnitude, partial product, quotient
//   and toe registers of the back pipeline; throughput: one request per cycle
//   while out_ch.ready is high, set by the front stage and the fully pipelined
//   back stages; when out_ch.ready is low the back pipeline holds, the queue
//   fills and then in_ch.ready drops; nothing is lost or repeated
//   reset clears all valid flags and queue pointers; no table state exists
module steering_toe_angle_interp (
    input  logic       clk,
    input  logic       rst_n,
    stai_in_if.sink    in_ch,
    stai_out_if.source out_ch
);
    import stai_pkg::*;

    logic    f_vld;
    item_t   f_item;
    logic    f_rdy;
    logic    q_vld;
    item_t   q_item;
    logic    q_pop;
    q_stat_t q_stat;

    stai_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .f_vld  (f_vld),
        .f_item (f_item),
        .f_rdy  (f_rdy)
    );

    stai_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_vld  (f_vld),
        .push_rdy  (f_rdy),
        .push_item (f_item),
        .pop_vld   (q_vld),
        .pop       (q_pop),
        .pop_item  (q_item),
        .stat      (q_stat)
    );

    stai_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_vld  (q_vld),
        .q_item (q_item),
        .q_pop  (q_pop),
        .out_ch (out_ch)
    );

    a_q_full_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_front_blocked : assert property (@(posedge clk) disable iff (!rst_n)
        (f_vld && q_stat.full) |-> !in_ch.ready)
        else $error("request taken while front stage is blocked");
endmodule

/* dv/stai_toe_checker.sv */
`timescale 1ns / 100ps
// stai_toe_checker: watches the angle and toe channels, predicts both toe angles
// and compares every result against the oldest outstanding prediction
// depends on stai_pkg, stai_in_if, stai_out_if
module stai_toe_checker (
    input  logic clk,
    input  logic rst_n,
    stai_in_if   in_mon,
    stai_out_if  out_mon,
    output int   errors,
    output int   pending,
    output int   checked,
    output int   below_cnt,
    output int   inside_cnt,
    output int   above_cnt
);
    import stai_pkg::*;

    localparam int POINTS   = 21;
    localparam int BP_FIRST = -23040;
    localparam int BP_LAST  = 23040;
    localparam int BP_PITCH = 2304;
    localparam int MAX_LINES = 100;
    localparam longint unsigned RAD_SCALE = 64'd2456332553;

    // left toe table in millidegrees, one entry per breakpoint
    localparam int TOE_TABLE [POINTS] = '{
        -32535, -29422, -26304, -23171, -20015, -16827, -13597, -10312, -6961,
        -3530, 0, 3648, 7441, 11413, 15608, 20092, 24959, 30368, 36611, 44391,
        57063
    };

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [TOE_W-1:0]   left;
        logic signed [TOE_W-1:0]   right;
    } toe_pair_t;

    toe_pair_t expected_toes [$];

    // millidegree ratio num/den to 2^-15 rad, nearest, halves away from zero
    function automatic int mdeg_to_toe_units(input longint num, input longint den);
        bit neg;
        longint unsigned mag;
        longint unsigned scaled_den;
        longint unsigned q;
        neg = (num < 0);
        mag = neg ? -num : num;
        scaled_den = longint'(den) << 32;
        q = (mag * RAD_SCALE + scaled_den / 2) / scaled_den;
        return neg ? -int'(q) : int'(q);
    endfunction

    function automatic int left_toe_at(input int a);
        int hit;
        longint lo_bp;
        longint lo_t;
        longint hi_t;
        longint num;
        hit = POINTS;
        for (int i = POINTS - 1; i >= 0; i--)
        begin
            if (BP_FIRST + i * BP_PITCH > a)
            begin
                hit = i;
            end
        end
        if (hit == POINTS)
        begin
            return mdeg_to_toe_units(TOE_TABLE[POINTS-1], 1);
        end
        if (hit == 0)
        begin
            return mdeg_to_toe_units(TOE_TABLE[0], 1);
        end
        lo_bp = BP_FIRST + (hit - 1) * BP_PITCH;
        lo_t  = TOE_TABLE[hit-1];
        hi_t  = TOE_TABLE[hit];
        num   = lo_t * BP_PITCH + (a - lo_bp) * (hi_t - lo_t);
        return mdeg_to_toe_units(num, BP_PITCH);
    endfunction

    function automatic toe_pair_t predict_toes(input logic signed [ANGLE_W-1:0] angle);
        toe_pair_t p;
        int a;
        a = int'(angle);
        p.angle = angle;
        p.left  = TOE_W'(left_toe_at(a));
        p.right = TOE_W'(-left_toe_at(-a));
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_LINES)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    always @(posedge clk)
    begin
        toe_pair_t want;
        int a;
        if (!rst_n)
        begin
            errors     = 0;
            pending    = 0;
            checked    = 0;
            below_cnt  = 0;
            inside_cnt = 0;
            above_cnt  = 0;
            expected_toes.delete();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_toes.size() == 0)
                begin
                    report_mismatch($sformatf("result with no request outstanding: left %0d right %0d",
                                              out_mon.left_toe, out_mon.right_toe));
                end
                else
                begin
                    want = expected_toes.pop_front();
                    checked++;
                    if (out_mon.left_toe !== want.left)
                    begin
                        report_mismatch($sformatf("left_toe for angle %0d: got %0d, want %0d",
                                                  want.angle, out_mon.left_toe, want.left));
                    end
                    if (out_mon.right_toe !== want.right)
                    begin
                        report_mismatch($sformatf("right_toe for angle %0d: got %0d, want %0d",
                                                  want.angle, out_mon.right_toe, want.right));
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                expected_toes.push_back(predict_toes(in_mon.steer_angle));
                a = int'(in_mon.steer_angle);
                if (a < BP_FIRST)
                begin
                    below_cnt++;
                end
                else if (a >= BP_LAST)
                begin
                    above_cnt++;
                end
                else
                begin
                    inside_cnt++;
                end
            end
            pending = expected_toes.size();
        end
    end

endmodule

/* dv/tb_steering_toe_angle_interp.sv */
`timescale 1ns / 100ps
// tb_steering_toe_angle_interp: drives steering angle requests with random idling
// and back-pressure, gives the verdict from the failure count of stai_toe_checker
// depends on stai_pkg, stai_in_if, stai_out_if, stai_toe_checker, steering_toe_angle_interp
module tb_steering_toe_angle_interp;
    import stai_pkg::*;

    localparam int RANDOM_ITEMS = 530;
    localparam int QUIET_TAIL   = 60;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;
    bit   quiet_tail;
    int   cycles;
    int   sent;
    int   errors;
    int   pending;
    int   checked;
    int   below_cnt;
    int   inside_cnt;
    int   above_cnt;

    stai_in_if  in_ch ();
    stai_out_if out_ch ();

    steering_toe_angle_interp u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    stai_toe_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .below_cnt  (below_cnt),
        .inside_cnt (inside_cnt),
        .above_cnt  (above_cnt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_angle(input logic signed [ANGLE_W-1:0] angle, input bit may_idle);
        int gap;
        if (may_idle && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            in_ch.steer_angle <= ANGLE_W'($urandom);
            gap = $urandom_range(1, 9);
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.steer_angle <= angle;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [ANGLE_W-1:0] random_angle();
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6:
            begin
                return ANGLE_W'(int'($urandom_range(0, 46080)) - 23040);
            end
            7, 8:
            begin
                // near a breakpoint
                k = $urandom_range(0, 20);
                return ANGLE_W'(-23040 + 2304 * k + int'($urandom_range(0, 4)) - 2);
            end
            default:
            begin
                return ANGLE_W'($urandom);
            end
        endcase
    endfunction

    localparam logic signed [ANGLE_W-1:0] DIRECTED [22] = '{
        -16'sd32768, -16'sd32767, -16'sd23041, -16'sd23040, -16'sd23039,
        -16'sd20737, -16'sd11520, -16'sd2304,  -16'sd1,     16'sd0,
        16'sd1,      16'sd1152,   16'sd2304,   16'sd11519,  16'sd20736,
        16'sd23039,  16'sd23040,  16'sd23041,  16'sd32767,  16'sh5555,
        -16'sh5556,  16'sd12345
    };

    // result side back-pressure
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (quiet_tail)
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        sent = 0;
        quiet_tail = 1'b0;
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.steer_angle <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_angle(DIRECTED[i], 1'b1);
        end
        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_TAIL);
            if (n == RANDOM_ITEMS / 2)
            begin
                hold_until_drained();
            end
            send_angle(random_angle(), 1'b1);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d steering angle requests, checked %0d toe results",
                 sent, checked);
        $display("angles below the table: %0d, interpolated: %0d, at or above the top: %0d",
                 below_cnt, inside_cnt, above_cnt);
        if (errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
